// File: src/pcr_pkg.sv
// Shared constants and types for the prime counting unit.
// No dependencies; imported by every module of the block.
package pcr_pkg;

	// Default value width of the bounds
	localparam int VALUE_WIDTH_DEF = 16;

	// Width and saturation limit of the count
	localparam int COUNT_WIDTH = 12;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Smallest prime, also the first trial divisor
	localparam int FIRST_PRIME = 2;

	// Status from the remainder unit back to the sequencer
	typedef struct packed {
		logic done;      // one-cycle pulse: remainder is ready
		logic rem_zero;  // divisor divides the dividend
	} pcr_div_stat_t;

endpackage

// File: src/pcr_rem_unit.sv
// Shared bit-serial remainder unit: one restoring step per cycle.
// Depends on pcr_pkg for the status struct.
module pcr_rem_unit import pcr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output pcr_div_stat_t          stat
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic          busy_q;
	logic [CW-1:0] step_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	pcr_div_stat_t stat_q;

	logic [W:0]    trial;
	logic [W-1:0]  rem_next;

	// Shift in the next dividend bit, subtract when the divisor fits
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[W-1:0];
		end
	end

	// Advance the iteration, pulse done after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			stat_q <= '0;
		end else begin
			stat_q.done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= CW'(W - 1);
			end else if (busy_q) begin
				step_q <= step_q - CW'(1);
				if (step_q == '0) begin
					busy_q          <= 1'b0;
					stat_q.done     <= 1'b1;
					stat_q.rem_zero <= (rem_next == '0);
				end
			end
		end
	end

	// Datapath registers: load on start, shift while busy
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign stat = stat_q;

endmodule

// File: src/prime_count_in_range_unit.sv
// Each candidate is tested by trial division up to its square root; each trial
// division is a launch, VALUE_WIDTH remainder steps in the shared unit, then the status.
// Throughput: one item at a time; busy drops in the cycle that done pulses.
// Reset: arst_n clears the sequencer, the count and the done strobe.
// Results pulse on done for one cycle; the receiver cannot stall.
module prime_count_in_range_unit import pcr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] bound_a,
	input  logic [VALUE_WIDTH-1:0] bound_b,
	output logic                   done,
	output logic [COUNT_WIDTH-1:0] prime_count
);

	localparam int W = VALUE_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CHECK,
		ST_TRIAL,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic                 done_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic signed [W-1:0]  lo_q;
	logic signed [W-1:0]  hi_q;
	logic [W-1:0]         cand_q;
	logic [W-1:0]         dsr_q;
	logic [W-1:0]         sq_q;

	logic                 a_lt_b;
	logic                 lo_pos;
	logic                 cand_lt_hi;
	logic                 div_start;
	pcr_div_stat_t        div_stat;

	// Sort bounds, range tests
	always_comb begin
		a_lt_b     = $signed(bound_a) < $signed(bound_b);
		lo_pos     = !lo_q[W-1] && (lo_q != '0);
		cand_lt_hi = !hi_q[W-1] && (cand_q < unsigned'(hi_q));
		div_start  = (state_q == ST_TRIAL) && (sq_q <= cand_q);
	end

	// Shared remainder unit
	pcr_rem_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q),
		.divisor  (dsr_q),
		.stat     (div_stat)
	);

	// Sequencer: walk candidates, walk divisors, count primes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= cand_lt_hi ? ST_TRIAL : ST_DONE;
				end
				ST_TRIAL: begin
					if (!div_start) begin
						// no divisor up to the square root: prime
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_WIDTH'(1);
						end
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						state_q <= div_stat.rem_zero ? ST_CHECK : ST_TRIAL;
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: bounds, candidate, divisor and its square
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (a_lt_b) begin
					lo_q <= bound_a;
					hi_q <= bound_b;
				end else begin
					lo_q <= bound_b;
					hi_q <= bound_a;
				end
			end
			ST_INIT: begin
				cand_q <= lo_pos ? unsigned'(lo_q) + W'(1) : W'(FIRST_PRIME);
			end
			ST_CHECK: begin
				dsr_q <= W'(FIRST_PRIME);
				sq_q  <= W'(FIRST_PRIME * FIRST_PRIME);
			end
			ST_TRIAL: begin
				if (!div_start) begin
					cand_q <= cand_q + W'(1);
				end
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					if (div_stat.rem_zero) begin
						cand_q <= cand_q + W'(1);
					end else begin
						// (d+1)^2 = d^2 + 2d + 1
						dsr_q <= dsr_q + W'(1);
						sq_q  <= sq_q + {dsr_q[W-2:0], 1'b0} + W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign prime_count = count_q;

endmodule

// File: src/pcr_checker.sv
// Port-level checks on the prime counting unit, bound to the top level.
// Depends on pcr_pkg and prime_count_in_range_unit.
module pcr_checker import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// Accepted item raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted item");

	// Result appears only while ready for the next item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// Every finished item gives a result as busy drops
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without result");

	// One strobe per item
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

bind prime_count_in_range_unit pcr_checker u_pcr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
